// ===== hdl/pso_pkg.sv =====
// Shared types and constants for the particle set overlap block.
package pso_pkg;

   // Default sizing
   localparam int DEPTH_DEFAULT    = 1024;
   localparam int ID_WIDTH_DEFAULT = 32;

   // Port field widths
   localparam int REQ_ID_W     = 32;
   localparam int RSP_COMMON_W = 11;
   localparam int RSP_RATE_W   = 15;
   localparam int RSP_DUP_W    = 10;

   // Rate scale: 100 percent with 8 fraction bits
   localparam int RATE_MULT   = 100 * 256;
   localparam int RATE_MULT_W = 15;

   // Request commands
   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPARE = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   // Compare sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AI_RD,
      ST_AI_LAT,
      ST_AJ_RD,
      ST_AJ_CMP,
      ST_BJ_RD,
      ST_BJ_CMP,
      ST_BI_RD,
      ST_BI_LAT,
      ST_BK_RD,
      ST_BK_CMP,
      ST_DIV_INIT,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ===== hdl/particle_set_overlap_top.sv =====
// Particle set overlap: list stores, compare sequencer and rate divider.
// Loads and clears are taken one request per cycle while idle.
// A compare scans the stores with one registered read per memory, alternating
// read and compare states, then runs a shift-subtract divider of NW bits
// (NW = clog2(DEPTH+1)+15) and holds the result until it is taken.
// No request is taken while a compare runs or its result waits.
// Synchronous reset empties both lists and clears the overflow flag.
module particle_set_overlap_top #(
   parameter int DEPTH    = pso_pkg::DEPTH_DEFAULT,
   parameter int ID_WIDTH = pso_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic [pso_pkg::REQ_ID_W-1:0]      req_particle_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pso_pkg::RSP_COMMON_W-1:0]  rsp_common_count,
   output logic [pso_pkg::RSP_RATE_W-1:0]    rsp_rate_percent_q8,
   output logic                              rsp_linked,
   output logic [pso_pkg::RSP_DUP_W-1:0]     rsp_dup_count_a,
   output logic [pso_pkg::RSP_DUP_W-1:0]     rsp_dup_count_b,
   output logic                              rsp_overflowed
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int NW  = CW + pso_pkg::RATE_MULT_W;
   localparam int KW  = $clog2(NW + 1);

   pso_pkg::state_type state_ff, state_in;

   // List memories
   logic [ID_WIDTH-1:0] mem_a [DEPTH];
   logic [ID_WIDTH-1:0] mem_b [DEPTH];
   logic [ID_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]       a_addr, b_addr;

   logic [CW-1:0]       count_a_ff, count_b_ff;
   logic                overflow_ff;
   logic [CW-1:0]       i_ff, j_ff;
   logic [ID_WIDTH-1:0] val_ff;
   logic [CW-1:0]       common_ff, dup_a_ff, dup_b_ff;
   logic [NW-1:0]       dvd_ff;
   logic [CW:0]         rem_ff;
   logic [KW-1:0]       step_ff;

   logic                req_fire, rsp_fire;
   logic [ID_WIDTH-1:0] id_in;
   logic [CW:0]         rem_sh;
   logic                q_bit;
   logic                i_last_a, i_last_b, j_last_i, j_last_b;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign id_in    = ID_WIDTH'(req_particle_id);

   assign i_last_a = (i_ff + CW'(1)) == count_a_ff;
   assign i_last_b = (i_ff + CW'(1)) == count_b_ff;
   assign j_last_i = (j_ff + CW'(1)) == i_ff;
   assign j_last_b = (j_ff + CW'(1)) == count_b_ff;

   // Divider step
   assign rem_sh = {rem_ff[CW-1:0], dvd_ff[NW-1]};
   assign q_bit  = rem_sh >= {1'b0, count_a_ff};

   // Read address selection
   always_comb begin
      a_addr = (state_ff == pso_pkg::ST_AJ_RD) ? j_ff[AW-1:0] : i_ff[AW-1:0];
      b_addr = (state_ff == pso_pkg::ST_BI_RD) ? i_ff[AW-1:0] : j_ff[AW-1:0];
   end

   // Memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (req_fire && req_cmd == pso_pkg::CMD_LOAD_A && count_a_ff != CW'(DEPTH)) begin
         mem_a[count_a_ff[AW-1:0]] <= id_in;
      end
      if (req_fire && req_cmd == pso_pkg::CMD_LOAD_B && count_b_ff != CW'(DEPTH)) begin
         mem_b[count_b_ff[AW-1:0]] <= id_in;
      end
      rd_a_ff <= mem_a[a_addr];
      rd_b_ff <= mem_b[b_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pso_pkg::ST_IDLE: begin
            if (req_fire && req_cmd == pso_pkg::CMD_COMPARE) begin
               if (count_a_ff != '0) state_in = pso_pkg::ST_AI_RD;
               else if (count_b_ff != '0) state_in = pso_pkg::ST_BI_RD;
               else state_in = pso_pkg::ST_DIV_INIT;
            end
         end
         pso_pkg::ST_AI_RD: state_in = pso_pkg::ST_AI_LAT;
         pso_pkg::ST_AI_LAT: begin
            if (i_ff != '0) state_in = pso_pkg::ST_AJ_RD;
            else if (count_b_ff != '0) state_in = pso_pkg::ST_BJ_RD;
            else if (!i_last_a) state_in = pso_pkg::ST_AI_RD;
            else state_in = pso_pkg::ST_DIV_INIT;
         end
         pso_pkg::ST_AJ_RD: state_in = pso_pkg::ST_AJ_CMP;
         pso_pkg::ST_AJ_CMP: begin
            if (rd_a_ff == val_ff || (j_last_i && count_b_ff == '0)) begin
               if (!i_last_a) state_in = pso_pkg::ST_AI_RD;
               else if (count_b_ff != '0) state_in = pso_pkg::ST_BI_RD;
               else state_in = pso_pkg::ST_DIV_INIT;
            end else if (j_last_i) begin
               state_in = pso_pkg::ST_BJ_RD;
            end else begin
               state_in = pso_pkg::ST_AJ_RD;
            end
         end
         pso_pkg::ST_BJ_RD: state_in = pso_pkg::ST_BJ_CMP;
         pso_pkg::ST_BJ_CMP: begin
            if (rd_b_ff == val_ff || j_last_b) begin
               if (!i_last_a) state_in = pso_pkg::ST_AI_RD;
               else state_in = pso_pkg::ST_BI_RD;
            end else begin
               state_in = pso_pkg::ST_BJ_RD;
            end
         end
         pso_pkg::ST_BI_RD: state_in = pso_pkg::ST_BI_LAT;
         pso_pkg::ST_BI_LAT: begin
            if (i_ff != '0) state_in = pso_pkg::ST_BK_RD;
            else if (!i_last_b) state_in = pso_pkg::ST_BI_RD;
            else state_in = pso_pkg::ST_DIV_INIT;
         end
         pso_pkg::ST_BK_RD: state_in = pso_pkg::ST_BK_CMP;
         pso_pkg::ST_BK_CMP: begin
            if (rd_b_ff == val_ff || j_last_i) begin
               if (!i_last_b) state_in = pso_pkg::ST_BI_RD;
               else state_in = pso_pkg::ST_DIV_INIT;
            end else begin
               state_in = pso_pkg::ST_BK_RD;
            end
         end
         pso_pkg::ST_DIV_INIT: state_in = pso_pkg::ST_DIV;
         pso_pkg::ST_DIV: begin
            if (step_ff == KW'(1)) state_in = pso_pkg::ST_OUT;
         end
         pso_pkg::ST_OUT: begin
            if (rsp_fire) state_in = pso_pkg::ST_IDLE;
         end
         default: state_in = pso_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_stall = state_ff != pso_pkg::ST_IDLE;
      rsp_valid = state_ff == pso_pkg::ST_OUT;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pso_pkg::ST_IDLE;
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            case (req_cmd)
               pso_pkg::CMD_LOAD_A: begin
                  if (count_a_ff != CW'(DEPTH)) count_a_ff <= count_a_ff + CW'(1);
                  else overflow_ff <= 1'b1;
               end
               pso_pkg::CMD_LOAD_B: begin
                  if (count_b_ff != CW'(DEPTH)) count_b_ff <= count_b_ff + CW'(1);
                  else overflow_ff <= 1'b1;
               end
               pso_pkg::CMD_CLEAR: begin
                  count_a_ff  <= '0;
                  count_b_ff  <= '0;
                  overflow_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (rsp_fire) count_b_ff <= '0;
      end
   end

   // Scan and divide datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         pso_pkg::ST_IDLE: begin
            i_ff      <= '0;
            j_ff      <= '0;
            common_ff <= '0;
            dup_a_ff  <= '0;
            dup_b_ff  <= '0;
         end
         pso_pkg::ST_AI_LAT: begin
            val_ff <= rd_a_ff;
            j_ff   <= '0;
            if (i_ff == '0 && count_b_ff == '0) begin
               i_ff <= i_last_a ? '0 : i_ff + CW'(1);
            end
         end
         pso_pkg::ST_AJ_CMP: begin
            if (rd_a_ff == val_ff) begin
               dup_a_ff <= dup_a_ff + CW'(1);
               i_ff     <= i_last_a ? '0 : i_ff + CW'(1);
            end else if (j_last_i) begin
               j_ff <= '0;
               if (count_b_ff == '0) i_ff <= i_last_a ? '0 : i_ff + CW'(1);
            end else begin
               j_ff <= j_ff + CW'(1);
            end
         end
         pso_pkg::ST_BJ_CMP: begin
            if (rd_b_ff == val_ff || j_last_b) begin
               if (rd_b_ff == val_ff) common_ff <= common_ff + CW'(1);
               i_ff <= i_last_a ? '0 : i_ff + CW'(1);
            end else begin
               j_ff <= j_ff + CW'(1);
            end
         end
         pso_pkg::ST_BI_LAT: begin
            val_ff <= rd_b_ff;
            j_ff   <= '0;
            if (i_ff == '0) i_ff <= i_ff + CW'(1);
         end
         pso_pkg::ST_BK_CMP: begin
            if (rd_b_ff == val_ff || j_last_i) begin
               if (rd_b_ff == val_ff) dup_b_ff <= dup_b_ff + CW'(1);
               i_ff <= i_ff + CW'(1);
            end else begin
               j_ff <= j_ff + CW'(1);
            end
         end
         pso_pkg::ST_DIV_INIT: begin
            dvd_ff  <= NW'(common_ff) * NW'(pso_pkg::RATE_MULT);
            rem_ff  <= '0;
            step_ff <= KW'(NW);
         end
         pso_pkg::ST_DIV: begin
            rem_ff  <= q_bit ? rem_sh - {1'b0, count_a_ff} : rem_sh;
            dvd_ff  <= {dvd_ff[NW-2:0], q_bit};
            step_ff <= step_ff - KW'(1);
         end
         default: ;
      endcase
   end

   // Result fields
   assign rsp_common_count    = pso_pkg::RSP_COMMON_W'(common_ff);
   assign rsp_rate_percent_q8 = (count_a_ff == '0) ? '0 : pso_pkg::RSP_RATE_W'(dvd_ff);
   assign rsp_linked          = (count_a_ff != '0) && (common_ff != '0);
   assign rsp_dup_count_a     = pso_pkg::RSP_DUP_W'(dup_a_ff);
   assign rsp_dup_count_b     = pso_pkg::RSP_DUP_W'(dup_b_ff);
   assign rsp_overflowed      = overflow_ff;

   // Checks
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");
   a_count_a_bound: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= CW'(DEPTH)) else $error("list A count past depth");
   a_common_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (common_ff + dup_a_ff <= count_a_ff))
      else $error("common plus duplicates exceed list A count");
   a_dup_b_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (dup_b_ff <= count_b_ff)) else $error("list B duplicates exceed count");
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pso_pkg::ST_IDLE && $past(state_ff) != pso_pkg::ST_IDLE && !$past(rsp_fire))
      |-> $stable(count_a_ff)) else $error("list A count changed during compare");

endmodule

// ===== dv/particle_set_overlap_top_tb.sv =====
// Testbench for particle_set_overlap_top: directed and random requests, scoreboard check.
module particle_set_overlap_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = pso_pkg::DEPTH_DEFAULT;
   localparam int N_ITEMS     = 1750;
   localparam int CYCLE_LIMIT = 8000000;

   // One overlap result as the block reports it
   typedef struct {
      logic [pso_pkg::RSP_COMMON_W-1:0] common_count;
      logic [pso_pkg::RSP_RATE_W-1:0]   rate;
      logic                             linked;
      logic [pso_pkg::RSP_DUP_W-1:0]    dup_a;
      logic [pso_pkg::RSP_DUP_W-1:0]    dup_b;
      logic                             overflowed;
   } overlap_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_cmd = pso_pkg::CMD_CLEAR;
   logic [pso_pkg::REQ_ID_W-1:0]     req_particle_id = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b1;
   logic [pso_pkg::RSP_COMMON_W-1:0] rsp_common_count;
   logic [pso_pkg::RSP_RATE_W-1:0]   rsp_rate_percent_q8;
   logic                             rsp_linked;
   logic [pso_pkg::RSP_DUP_W-1:0]    rsp_dup_count_a;
   logic [pso_pkg::RSP_DUP_W-1:0]    rsp_dup_count_b;
   logic                             rsp_overflowed;

   // Shadow of the block's lists
   logic [31:0]        list_a[$];
   logic [31:0]        list_b[$];
   logic               overflow_seen;
   overlap_result_type pending_overlaps[$];

   int  failures    = 0;
   int  sent        = 0;
   int  cycles      = 0;
   bit  no_idle     = 0;
   int  rsp_holdoff = 0;

   particle_set_overlap_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_particle_id(req_particle_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_common_count(rsp_common_count), .rsp_rate_percent_q8(rsp_rate_percent_q8),
      .rsp_linked(rsp_linked), .rsp_dup_count_a(rsp_dup_count_a),
      .rsp_dup_count_b(rsp_dup_count_b), .rsp_overflowed(rsp_overflowed)
   );

   always #10 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL particle_set_overlap_top");
         $finish;
      end
   end

   // Sort a list and drop repeats
   function automatic void sort_distinct(input logic [31:0] src[$], output logic [31:0] dst[$]);
      logic [31:0] tmp[$];
      tmp = src;
      tmp.sort();
      dst = {};
      foreach (tmp[i])
         if (dst.size() == 0 || dst[dst.size()-1] != tmp[i]) dst.insert(dst.size(), tmp[i]);
   endfunction

   // Overlap of the shadow lists at a compare
   function automatic overlap_result_type predict_overlap();
      overlap_result_type r;
      logic [31:0] ua[$];
      logic [31:0] ub[$];
      bit in_b[logic [31:0]];
      int common;
      longint scaled;
      sort_distinct(list_a, ua);
      sort_distinct(list_b, ub);
      foreach (ub[i]) in_b[ub[i]] = 1'b1;
      common = 0;
      foreach (ua[i]) if (in_b.exists(ua[i])) common++;
      scaled = 0;
      if (list_a.size() > 0) begin
         scaled = (longint'(common) * pso_pkg::RATE_MULT) / list_a.size();
      end
      r.common_count = pso_pkg::RSP_COMMON_W'(common);
      r.rate         = scaled[pso_pkg::RSP_RATE_W-1:0];
      r.linked       = (list_a.size() > 0) && (common > 0);
      r.dup_a        = pso_pkg::RSP_DUP_W'(list_a.size() - ua.size());
      r.dup_b        = pso_pkg::RSP_DUP_W'(list_b.size() - ub.size());
      r.overflowed   = overflow_seen;
      return r;
   endfunction

   // Update the shadow for one accepted request
   task automatic track_request(input pso_pkg::cmd_type cmd, input logic [31:0] id);
      case (cmd)
         pso_pkg::CMD_LOAD_A: begin
            if (list_a.size() < DEPTH) list_a.insert(list_a.size(), id);
            else overflow_seen = 1'b1;
         end
         pso_pkg::CMD_LOAD_B: begin
            if (list_b.size() < DEPTH) list_b.insert(list_b.size(), id);
            else overflow_seen = 1'b1;
         end
         pso_pkg::CMD_COMPARE: begin
            pending_overlaps.insert(pending_overlaps.size(), predict_overlap());
            list_b = {};
         end
         pso_pkg::CMD_CLEAR: begin
            list_a = {};
            list_b = {};
            overflow_seen = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Offer one request and wait for it to be taken
   task automatic send_request(input pso_pkg::cmd_type cmd, input logic [31:0] id);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_particle_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_request(cmd, id);
      sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_overlaps.size() != 0) @(posedge clock);
   endtask

   // Result side: random stall, then check against the oldest expectation
   initial begin
      overlap_result_type exp_r;
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_holdoff > 0) begin
            n = rsp_holdoff;
            rsp_holdoff = 0;
         end else n = no_idle ? 0 : $urandom_range(0, 19);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_overlaps.size() == 0) begin
            $error("unexpected result, common_count %0d", rsp_common_count);
            failures++;
         end else begin
            exp_r = pending_overlaps.pop_front();
            if (rsp_common_count !== exp_r.common_count) begin
               $error("common_count exp %0d got %0d", exp_r.common_count, rsp_common_count);
               failures++;
            end
            if (rsp_rate_percent_q8 !== exp_r.rate) begin
               $error("rate_percent_q8 exp %0d got %0d", exp_r.rate, rsp_rate_percent_q8);
               failures++;
            end
            if (rsp_linked !== exp_r.linked) begin
               $error("linked exp %0d got %0d", exp_r.linked, rsp_linked);
               failures++;
            end
            if (rsp_dup_count_a !== exp_r.dup_a) begin
               $error("dup_count_a exp %0d got %0d", exp_r.dup_a, rsp_dup_count_a);
               failures++;
            end
            if (rsp_dup_count_b !== exp_r.dup_b) begin
               $error("dup_count_b exp %0d got %0d", exp_r.dup_b, rsp_dup_count_b);
               failures++;
            end
            if (rsp_overflowed !== exp_r.overflowed) begin
               $error("overflowed exp %0d got %0d", exp_r.overflowed, rsp_overflowed);
               failures++;
            end
         end
         @(negedge clock);
      end
   end

   // Extreme IDs, duplicates, full overlap, ignored IDs on compare and clear
   task automatic test_basic_overlap();
      send_request(pso_pkg::CMD_LOAD_A, 32'h0000_0000);
      send_request(pso_pkg::CMD_LOAD_A, 32'hFFFF_FFFF);
      send_request(pso_pkg::CMD_LOAD_A, 32'h0000_0000);
      send_request(pso_pkg::CMD_LOAD_B, 32'hFFFF_FFFF);
      send_request(pso_pkg::CMD_LOAD_B, 32'h0000_0005);
      send_request(pso_pkg::CMD_LOAD_B, 32'h0000_0005);
      send_request(pso_pkg::CMD_COMPARE, 32'hFFFF_FFFF);
      send_request(pso_pkg::CMD_CLEAR, 32'hA5A5_5A5A);
      send_request(pso_pkg::CMD_LOAD_A, 32'h8000_0001);
      send_request(pso_pkg::CMD_LOAD_A, 32'h7FFF_FFFE);
      send_request(pso_pkg::CMD_LOAD_B, 32'h7FFF_FFFE);
      send_request(pso_pkg::CMD_LOAD_B, 32'h8000_0001);
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
   endtask

   // Empty B (A kept), both empty, empty A
   task automatic test_empty_lists();
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
      send_request(pso_pkg::CMD_CLEAR, 32'h0);
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
      send_request(pso_pkg::CMD_LOAD_B, 32'h1234_5678);
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
   endtask

   // Fill list A, drop a load; flag shows on compare and goes on clear
   task automatic test_overflow();
      send_request(pso_pkg::CMD_CLEAR, 32'h0);
      no_idle = 1;
      for (int i = 0; i < DEPTH; i++) send_request(pso_pkg::CMD_LOAD_A, 32'(i % 1000));
      send_request(pso_pkg::CMD_LOAD_A, 32'hDEAD_BEEF);
      no_idle = 0;
      send_request(pso_pkg::CMD_LOAD_B, 32'd7);
      send_request(pso_pkg::CMD_LOAD_B, 32'hDEAD_BEEF);
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
      send_request(pso_pkg::CMD_CLEAR, 32'h0);
      send_request(pso_pkg::CMD_LOAD_A, 32'd3);
      send_request(pso_pkg::CMD_LOAD_B, 32'd3);
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
   endtask

   // Receiver holds off while the sender keeps offering requests
   task automatic test_backpressure();
      wait_drained();
      rsp_holdoff = 400;
      send_request(pso_pkg::CMD_LOAD_B, 32'd3);
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
      for (int i = 0; i < 4; i++) send_request(pso_pkg::CMD_LOAD_B, 32'(i));
      send_request(pso_pkg::CMD_COMPARE, 32'h0);
   endtask

   function automatic logic [31:0] pick_id();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return $urandom_range(0, 15) ^ ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0);
   endfunction

   // Random load/compare sequences with some noise
   task automatic test_random();
      int na, nb;
      while (sent < N_ITEMS) begin
         no_idle = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 9) == 0) begin
            send_request(pso_pkg::cmd_type'($urandom_range(0, 3)), $urandom());
         end else begin
            if ($urandom_range(0, 3) != 0) begin
               if ($urandom_range(0, 1)) send_request(pso_pkg::CMD_CLEAR, $urandom());
               na = $urandom_range(0, 12);
               for (int i = 0; i < na; i++) send_request(pso_pkg::CMD_LOAD_A, pick_id());
            end
            nb = $urandom_range(0, 12);
            for (int i = 0; i < nb; i++) send_request(pso_pkg::CMD_LOAD_B, pick_id());
            send_request(pso_pkg::CMD_COMPARE, $urandom());
         end
      end
      no_idle = 0;
   endtask

   initial begin
      overflow_seen = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_overlap();
      test_empty_lists();
      test_overflow();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (200) @(posedge clock);
      if (failures == 0) $display("PASS particle_set_overlap_top");
      else $display("FAIL particle_set_overlap_top");
      $finish;
   end

endmodule
